### hw/rtl/wsfd_pkg.sv
// shared types and constants for the websocket frame deframer
package wsfd_pkg;

	// header walk phases
	typedef enum logic [2:0] {
		PH_FIRST,
		PH_SECOND,
		PH_EXT16,
		PH_EXT64,
		PH_KEY,
		PH_PAYLOAD
	} phase_t;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// header byte counts at which a field is complete
	localparam logic [2:0] EXT16_END = 3'd2;
	// eight bytes, the 3-bit count wraps to zero
	localparam logic [2:0] EXT64_END = 3'd0;
	localparam logic [2:0] KEY_END   = 3'd4;

	localparam int QUEUE_DEPTH = 4;

	// one classified word passed from the front to the back
	typedef struct packed {
		logic [7:0]  raw_byte;
		logic [7:0]  key_byte;
		logic        has_data;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] length;
		logic        last;
	} item_t;

endpackage

### hw/rtl/wsfd_front.sv
// header parser: walks the frame header and classifies each byte
module wsfd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [7:0]     in_byte,
	output logic           push,
	output wsfd_pkg::item_t push_item
);

	wsfd_pkg::phase_t phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        mask_q, mask_d;
	logic [63:0] len_q, len_d;
	logic [2:0]  hcnt_q, hcnt_d;
	logic [31:0] key_q, key_d;
	logic [63:0] rem_q, rem_d;
	logic [1:0]  kpos_q, kpos_d;

	logic        done_len;
	logic        start_pl;
	logic [7:0]  key_sel;
	logic [63:0] rem_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsfd_pkg::PH_FIRST;
			opcode_q <= 4'd0;
			mask_q   <= 1'b0;
			len_q    <= 64'd0;
			hcnt_q   <= 3'd0;
			key_q    <= 32'd0;
			rem_q    <= 64'd0;
			kpos_q   <= 2'd0;
		end else begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			mask_q   <= mask_d;
			len_q    <= len_d;
			hcnt_q   <= hcnt_d;
			key_q    <= key_d;
			rem_q    <= rem_d;
			kpos_q   <= kpos_d;
		end
	end

	always_comb begin
		unique case (kpos_q)
			2'd0: key_sel = key_q[31:24];
			2'd1: key_sel = key_q[23:16];
			2'd2: key_sel = key_q[15:8];
			2'd3: key_sel = key_q[7:0];
			default: key_sel = 8'd0;
		endcase
	end

	assign rem_dec = (rem_q != 64'd0) ? (rem_q - 64'd1) : rem_q;

	always_comb begin
		phase_d  = phase_q;
		opcode_d = opcode_q;
		mask_d   = mask_q;
		len_d    = len_q;
		hcnt_d   = hcnt_q;
		key_d    = key_q;
		rem_d    = rem_q;
		kpos_d   = kpos_q;
		done_len = 1'b0;
		start_pl = 1'b0;
		push     = 1'b0;
		push_item.raw_byte = 8'd0;
		push_item.key_byte = 8'd0;
		push_item.has_data = 1'b0;
		push_item.last     = 1'b0;
		if (take) begin
			unique case (phase_q)
				wsfd_pkg::PH_FIRST: begin
					opcode_d = in_byte[3:0];
					phase_d  = wsfd_pkg::PH_SECOND;
				end
				wsfd_pkg::PH_SECOND: begin
					mask_d = in_byte[7];
					len_d  = 64'd0;
					hcnt_d = 3'd0;
					if (in_byte[6:0] == wsfd_pkg::LEN_EXT16) begin
						phase_d = wsfd_pkg::PH_EXT16;
					end else if (in_byte[6:0] == wsfd_pkg::LEN_EXT64) begin
						phase_d = wsfd_pkg::PH_EXT64;
					end else begin
						len_d    = {57'd0, in_byte[6:0]};
						done_len = 1'b1;
					end
				end
				wsfd_pkg::PH_EXT16, wsfd_pkg::PH_EXT64: begin
					len_d  = {len_q[55:0], in_byte};
					hcnt_d = hcnt_q + 3'd1;
					if ((phase_q == wsfd_pkg::PH_EXT16 && hcnt_d == wsfd_pkg::EXT16_END) ||
					    (phase_q == wsfd_pkg::PH_EXT64 && hcnt_d == wsfd_pkg::EXT64_END))
						done_len = 1'b1;
				end
				wsfd_pkg::PH_KEY: begin
					key_d  = {key_q[23:0], in_byte};
					hcnt_d = hcnt_q + 3'd1;
					if (hcnt_d == wsfd_pkg::KEY_END)
						start_pl = 1'b1;
				end
				wsfd_pkg::PH_PAYLOAD: begin
					kpos_d = kpos_q + 2'd1;
					rem_d  = rem_dec;
					push   = 1'b1;
					push_item.raw_byte = in_byte;
					push_item.key_byte = mask_q ? key_sel : 8'd0;
					push_item.has_data = 1'b1;
					push_item.last     = (rem_dec == 64'd0);
					if (rem_dec == 64'd0) begin
						phase_d = wsfd_pkg::PH_FIRST;
						kpos_d  = 2'd0;
					end
				end
				default: begin
					phase_d = wsfd_pkg::PH_FIRST;
				end
			endcase

			if (done_len) begin
				hcnt_d = 3'd0;
				if (mask_d) begin
					key_d   = 32'd0;
					phase_d = wsfd_pkg::PH_KEY;
				end else begin
					start_pl = 1'b1;
				end
			end

			if (start_pl) begin
				kpos_d = 2'd0;
				hcnt_d = 3'd0;
				rem_d  = len_d;
				if (len_d == 64'd0) begin
					// empty frame gives one marker word
					phase_d = wsfd_pkg::PH_FIRST;
					push    = 1'b1;
					push_item.last = 1'b1;
				end else begin
					phase_d = wsfd_pkg::PH_PAYLOAD;
				end
			end
		end
		push_item.opcode = opcode_d;
		push_item.masked = mask_d;
		push_item.length = len_d;
	end

endmodule

### hw/rtl/wsfd_queue.sv
// short fifo between the header parser and the output stage
module wsfd_queue #(
	parameter int Depth = wsfd_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wsfd_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output wsfd_pkg::item_t pop_item,
	output logic            not_empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	wsfd_pkg::item_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full      = (cnt_q == CntFull);
	assign not_empty = (cnt_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CntW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CntW'(1);
		end
	end

endmodule

### hw/rtl/wsfd_back.sv
// output stage: unmasks the payload byte and holds the result word
module wsfd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  wsfd_pkg::item_t q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      payload_byte,
	output logic            has_data,
	output logic [3:0]      frame_opcode,
	output logic            was_masked,
	output logic [63:0]     frame_length,
	output logic            last_of_frame
);

	logic        valid_q;
	logic [7:0]  byte_q;
	logic        has_q;
	logic [3:0]  opcode_q;
	logic        masked_q;
	logic [63:0] length_q;
	logic        last_q;

	assign q_pop = q_valid && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_pop)
			valid_q <= 1'b1;
		else if (!out_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			byte_q   <= q_item.raw_byte ^ q_item.key_byte;
			has_q    <= q_item.has_data;
			opcode_q <= q_item.opcode;
			masked_q <= q_item.masked;
			length_q <= q_item.length;
			last_q   <= q_item.last;
		end
	end

	assign out_valid     = valid_q;
	assign payload_byte  = byte_q;
	assign has_data      = has_q;
	assign frame_opcode  = opcode_q;
	assign was_masked    = masked_q;
	assign frame_length  = length_q;
	assign last_of_frame = last_q;

endmodule

### hw/rtl/websocket_frame_deframer_core.sv
// top level of the websocket frame deframer
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in      | input     | in_valid / in_stall  | in_byte
//  out     | output    | out_valid / out_stall| payload_byte, has_data, frame_opcode,
//          |           |                      | was_masked, frame_length, last_of_frame
//
// one byte is taken per cycle while in_stall is low; the parser is combinational, so a
// payload byte or an empty-frame marker enters the queue at the edge that takes its input
// byte and is then moved from the queue into the output register.
// in_stall is high only while the queue between parser and output stage is full,
// which happens only when out_stall holds results back.
// arst_n clears the parser to expect a first header byte and empties the queue.
module websocket_frame_deframer_core #(
	parameter int QueueDepth = wsfd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  payload_byte,
	output logic        has_data,
	output logic [3:0]  frame_opcode,
	output logic        was_masked,
	output logic [63:0] frame_length,
	output logic        last_of_frame
);

	logic            take;
	logic            push;
	wsfd_pkg::item_t push_item;
	logic            full;
	logic            pop;
	wsfd_pkg::item_t pop_item;
	logic            not_empty;

	assign in_stall = full;
	assign take     = in_valid && !full;

	wsfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (in_byte),
		.push      (push),
		.push_item (push_item)
	);

	wsfd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (not_empty)
	);

	wsfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (not_empty),
		.q_item        (pop_item),
		.q_pop         (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_byte  (payload_byte),
		.has_data      (has_data),
		.frame_opcode  (frame_opcode),
		.was_masked    (was_masked),
		.frame_length  (frame_length),
		.last_of_frame (last_of_frame)
	);

endmodule

### dv/wsfd_checker.sv
// output checker for the websocket frame deframer: tracks the header walk and compares each word
`timescale 1ns / 1ps
module wsfd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  payload_byte,
	input  logic        has_data,
	input  logic [3:0]  frame_opcode,
	input  logic        was_masked,
	input  logic [63:0] frame_length,
	input  logic        last_of_frame,
	output int          fails,
	output int          pending
);

	typedef struct packed {
		logic [7:0]  data;
		logic        has;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] length;
		logic        last;
	} out_word_t;

	wsfd_pkg::phase_t phase = wsfd_pkg::PH_FIRST;
	logic [3:0]  op_q = '0;
	logic        masked_q = 1'b0;
	logic [63:0] len_q = '0;
	logic [2:0]  hdr_cnt = '0;
	logic [31:0] key_q = '0;
	logic [63:0] remaining = '0;
	logic [1:0]  key_pos = '0;
	out_word_t   expected_q[$];

	initial begin
		fails = 0;
		pending = 0;
	end

	function automatic out_word_t make_word(input logic [7:0] data, input logic has,
		input logic last);
		return {data, has, op_q, masked_q, len_q, last};
	endfunction

	// length and key are in: either an empty-frame marker or the payload begins
	function automatic bit start_payload(output out_word_t w);
		key_pos = '0;
		hdr_cnt = '0;
		remaining = len_q;
		w = '0;
		if (len_q == '0) begin
			phase = wsfd_pkg::PH_FIRST;
			w = make_word(8'h00, 1'b0, 1'b1);
			return 1'b1;
		end
		phase = wsfd_pkg::PH_PAYLOAD;
		return 1'b0;
	endfunction

	function automatic bit length_known(output out_word_t w);
		hdr_cnt = '0;
		w = '0;
		if (masked_q) begin
			key_q = '0;
			phase = wsfd_pkg::PH_KEY;
			return 1'b0;
		end
		return start_payload(w);
	endfunction

	function automatic bit deframe_byte(input logic [7:0] b, output out_word_t w);
		logic [7:0] data;
		logic [2:0] need;
		bit         emit;
		emit = 1'b0;
		w = '0;
		case (phase)
		wsfd_pkg::PH_FIRST: begin
			op_q = b[3:0];
			phase = wsfd_pkg::PH_SECOND;
		end
		wsfd_pkg::PH_SECOND: begin
			masked_q = b[7];
			len_q = '0;
			hdr_cnt = '0;
			if (b[6:0] == wsfd_pkg::LEN_EXT16) begin
				phase = wsfd_pkg::PH_EXT16;
			end else if (b[6:0] == wsfd_pkg::LEN_EXT64) begin
				phase = wsfd_pkg::PH_EXT64;
			end else begin
				len_q = 64'(b[6:0]);
				emit = length_known(w);
			end
		end
		wsfd_pkg::PH_EXT16, wsfd_pkg::PH_EXT64: begin
			need = (phase == wsfd_pkg::PH_EXT16) ? wsfd_pkg::EXT16_END : wsfd_pkg::EXT64_END;
			len_q = {len_q[55:0], b};
			hdr_cnt = hdr_cnt + 3'd1;
			if (hdr_cnt == need) begin
				emit = length_known(w);
			end
		end
		wsfd_pkg::PH_KEY: begin
			key_q = {key_q[23:0], b};
			hdr_cnt = hdr_cnt + 3'd1;
			if (hdr_cnt == wsfd_pkg::KEY_END) begin
				emit = start_payload(w);
			end
		end
		wsfd_pkg::PH_PAYLOAD: begin
			data = b;
			// first key byte sits in the top bits
			if (masked_q) begin
				data = b ^ key_q[8 * (3 - key_pos) +: 8];
			end
			key_pos = key_pos + 2'd1;
			if (remaining != '0) begin
				remaining = remaining - 64'd1;
			end
			w = make_word(data, 1'b1, remaining == '0);
			if (remaining == '0) begin
				phase = wsfd_pkg::PH_FIRST;
				key_pos = '0;
			end
			emit = 1'b1;
		end
		default: begin
			phase = wsfd_pkg::PH_FIRST;
		end
		endcase
		return emit;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			fails++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_word_t want;
		out_word_t got;
		if (!arst_n) begin
			phase = wsfd_pkg::PH_FIRST;
			op_q = '0;
			masked_q = 1'b0;
			len_q = '0;
			hdr_cnt = '0;
			key_q = '0;
			remaining = '0;
			key_pos = '0;
			expected_q.delete();
			pending <= 0;
		end else begin
			if (in_valid && !in_stall && deframe_byte(in_byte, want)) begin
				expected_q.push_back(want);
			end
			if (out_valid && !out_stall) begin
				got = {payload_byte, has_data, frame_opcode, was_masked, frame_length,
					last_of_frame};
				if (expected_q.size() == 0) begin
					fails++;
					$display("%0t: word expected none actual %h", $time, got);
				end else begin
					want = expected_q.pop_front();
					check_field("payload_byte", 64'(want.data), 64'(got.data));
					check_field("has_data", 64'(want.has), 64'(got.has));
					check_field("frame_opcode", 64'(want.opcode), 64'(got.opcode));
					check_field("was_masked", 64'(want.masked), 64'(got.masked));
					check_field("frame_length", want.length, got.length);
					check_field("last_of_frame", 64'(want.last), 64'(got.last));
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

### dv/tb_top.sv
// testbench top for the websocket frame deframer: frame stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_top;

	typedef enum int {SHORT_LEN, EXT16_LEN, EXT64_LEN} len_form_t;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_BYTES  = 600;
	localparam int SETTLE_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  in_byte = '0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [7:0]  payload_byte;
	logic        has_data;
	logic [3:0]  frame_opcode;
	logic        was_masked;
	logic [63:0] frame_length;
	logic        last_of_frame;

	int fails;
	int pending;
	int cycles = 0;
	int bytes_sent = 0;
	bit src_idle = 1'b1;
	bit sink_idle = 1'b1;

	websocket_frame_deframer_core uut (.*);
	wsfd_checker checker_i (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// receiver: random stall before each word while sink_idle is set
	initial begin : sink
		int gap;
		forever begin
			gap = sink_idle ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = src_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		bytes_sent++;
	endtask

	// body is how many payload bytes go out, normally the header length
	task automatic send_frame(input logic [7:0] head, input bit masked, input len_form_t form,
		input logic [63:0] flen, input int body);
		logic [31:0] key;
		int          i;
		key = $urandom();
		send_byte(head);
		case (form)
		SHORT_LEN: begin
			send_byte({masked, flen[6:0]});
		end
		EXT16_LEN: begin
			send_byte({masked, wsfd_pkg::LEN_EXT16});
			for (i = 1; i >= 0; i--) send_byte(flen[8 * i +: 8]);
		end
		default: begin
			send_byte({masked, wsfd_pkg::LEN_EXT64});
			for (i = 7; i >= 0; i--) send_byte(flen[8 * i +: 8]);
		end
		endcase
		if (masked) begin
			for (i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
		end
		for (i = 0; i < body; i++) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int          start;
		int          frame_idx;
		int          pick;
		int          quarter;
		bit          masked;
		bit          drained;
		len_form_t   form;
		logic [63:0] flen;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty frames in every length form, then short payloads
		send_frame(8'h81, 1'b0, SHORT_LEN, 64'd0, 0);
		send_frame(8'hFF, 1'b1, SHORT_LEN, 64'd0, 0);
		send_frame(8'h00, 1'b0, EXT16_LEN, 64'd0, 0);
		send_frame(8'h7A, 1'b1, EXT64_LEN, 64'd0, 0);
		send_frame(8'h02, 1'b0, SHORT_LEN, 64'd3, 3);
		// key position wraps past four
		send_frame(8'h82, 1'b1, SHORT_LEN, 64'd6, 6);
		// non-minimal length encodings
		send_frame(8'h01, 1'b0, EXT16_LEN, 64'd5, 5);
		send_frame(8'h09, 1'b1, EXT64_LEN, 64'd2, 2);
		drain_results();

		start = bytes_sent;
		frame_idx = 0;
		drained = 1'b0;
		while (bytes_sent < start + RANDOM_BYTES) begin
			quarter = 4 * (bytes_sent - start) / RANDOM_BYTES;
			case (quarter)
			0: begin src_idle = 1'b1; sink_idle = 1'b1; end
			1: begin src_idle = 1'b0; sink_idle = 1'b0; end
			2: begin src_idle = 1'b1; sink_idle = 1'b0; end
			default: begin src_idle = 1'b0; sink_idle = 1'b1; end
			endcase
			pick = $urandom_range(0, 19);
			masked = 1'($urandom_range(0, 1));
			if (pick < 12) begin
				form = SHORT_LEN;
				flen = (pick == 0) ? 64'($urandom_range(100, 125)) : 64'($urandom_range(0, 20));
			end else if (pick < 16) begin
				form = EXT16_LEN;
				flen = 64'($urandom_range(0, 40));
			end else begin
				form = EXT64_LEN;
				flen = 64'($urandom_range(0, 40));
			end
			// opcode walks through all sixteen values, fin and rsv bits random
			send_frame({4'($urandom()), 4'(frame_idx)}, masked, form, flen, int'(flen));
			frame_idx++;
			if (!drained && bytes_sent >= start + RANDOM_BYTES / 2) begin
				drain_results();
				drained = 1'b1;
			end
		end

		// every length bit set: the frame stays open for the rest of the run
		src_idle = 1'b1;
		sink_idle = 1'b1;
		send_frame(8'h8F, 1'b1, EXT64_LEN, '1, 5);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fails == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
